[rtl/rpa_pkg.sv]
// shared types, constants and helpers for the rgba pre-integration accumulator
package rpa_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int INTEGRAL_W = 24;
    localparam int PROD_W     = 31;
    localparam int SUM_W      = 32;
    localparam int ASUM_W     = 17;

    localparam logic [SAMPLE_W-1:0]   ONE_Q15 = 16'h8000;
    localparam logic [INTEGRAL_W-1:0] ONE_Q23 = 24'h80_0000;

    typedef logic [SAMPLE_W-1:0]   sample_t;
    typedef logic [INTEGRAL_W-1:0] integral_t;
    typedef logic [PROD_W-1:0]     prod_t;

    typedef struct packed {
        logic load;
        logic scale;
        logic commit;
        logic first;
    } lane_ctrl_t;

    function automatic sample_t sat_q15(input sample_t v);
        sat_q15 = (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

    function automatic integral_t acc_update(input integral_t acc, input integral_t inc,
                                             input logic first);
        logic [INTEGRAL_W:0] s;
        s = {1'b0, acc} + {1'b0, inc};
        if (first)
        begin
            acc_update = '0;
        end
        else if (s > {1'b0, ONE_Q23})
        begin
            acc_update = ONE_Q23;
        end
        else
        begin
            acc_update = s[INTEGRAL_W-1:0];
        end
    endfunction

endpackage

[rtl/rpa_color_lane.sv]
// one color lane: alpha weighting, trapezoid scaling and saturating accumulation
module rpa_color_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  rpa_pkg::lane_ctrl_t ctrl,
    input  rpa_pkg::sample_t    color,
    input  rpa_pkg::sample_t    alpha,
    input  rpa_pkg::sample_t    prev_alpha,
    input  rpa_pkg::sample_t    step,
    output rpa_pkg::integral_t  integral
);
    import rpa_pkg::*;

    sample_t   prev_color_reg;
    prod_t     prod_cur_reg;
    prod_t     prod_prev_reg;
    integral_t inc_reg;
    integral_t acc_reg;

    logic [2*SAMPLE_W-1:0]        prod_cur_full;
    logic [2*SAMPLE_W-1:0]        prod_prev_full;
    logic [SUM_W-1:0]             sum;
    logic [SAMPLE_W+SUM_W-1:0]    scaled;
    integral_t                    inc_next;
    integral_t                    acc_next;

    assign prod_cur_full  = {{SAMPLE_W{1'b0}}, color} * {{SAMPLE_W{1'b0}}, alpha};
    assign prod_prev_full = {{SAMPLE_W{1'b0}}, prev_color_reg} * {{SAMPLE_W{1'b0}}, prev_alpha};
    assign sum            = {1'b0, prod_cur_reg} + {1'b0, prod_prev_reg};
    assign scaled         = {{SUM_W{1'b0}}, step} * {{SAMPLE_W{1'b0}}, sum};
    assign inc_next       = scaled[INTEGRAL_W+22:23];
    assign acc_next       = acc_update(acc_reg, inc_reg, ctrl.first);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_color_reg <= '0;
            acc_reg        <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                prev_color_reg <= color;
            end
            if (ctrl.commit)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_cur_reg  <= prod_cur_full[PROD_W-1:0];
            prod_prev_reg <= prod_prev_full[PROD_W-1:0];
        end
        if (ctrl.scale)
        begin
            inc_reg <= inc_next;
        end
    end

    assign integral = acc_reg;

endmodule

[rtl/rpa_alpha_lane.sv]
// alpha lane: keeps the previous opacity and accumulates the opacity integral
module rpa_alpha_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  rpa_pkg::lane_ctrl_t ctrl,
    input  rpa_pkg::sample_t    alpha,
    input  rpa_pkg::sample_t    step,
    output rpa_pkg::sample_t    prev_alpha,
    output rpa_pkg::integral_t  integral
);
    import rpa_pkg::*;

    sample_t            prev_alpha_reg;
    logic [ASUM_W-1:0]  asum_reg;
    integral_t          inc_reg;
    integral_t          acc_reg;

    logic [SAMPLE_W+ASUM_W-1:0] scaled;
    integral_t                  acc_next;

    assign scaled   = {{ASUM_W{1'b0}}, step} * {{SAMPLE_W{1'b0}}, asum_reg};
    assign acc_next = acc_update(acc_reg, inc_reg, ctrl.first);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_alpha_reg <= '0;
            acc_reg        <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                prev_alpha_reg <= alpha;
            end
            if (ctrl.commit)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            asum_reg <= {1'b0, alpha} + {1'b0, prev_alpha_reg};
        end
        if (ctrl.scale)
        begin
            inc_reg <= scaled[INTEGRAL_W+7:8];
        end
    end

    assign prev_alpha = prev_alpha_reg;
    assign integral   = acc_reg;

endmodule

[rtl/rgba_preintegration_accumulator.sv]
// top level: input sequencing, step register, four lanes and the result word register
// Each input word produces one result word. A word passes through three registers in every
// lane (weighted products, step scaling, saturating accumulate), and a new word is taken only
// when the lanes hold no word in flight, that is, only after the last word was committed;
// a stalled output holds off that commit. The finished result is held on the output while
// the next word is already being processed. The step size resets to 128 and is written through
// the cfg channel, which is always ready; write it only while the block is idle.
module rgba_preintegration_accumulator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  rpa_pkg::sample_t    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  rpa_pkg::sample_t    red_sample,
    input  rpa_pkg::sample_t    green_sample,
    input  rpa_pkg::sample_t    blue_sample,
    input  rpa_pkg::sample_t    alpha_sample,
    input  logic                first_sample,
    output logic                out_valid,
    input  logic                out_stall,
    output rpa_pkg::integral_t  red_integral,
    output rpa_pkg::integral_t  green_integral,
    output rpa_pkg::integral_t  blue_integral,
    output rpa_pkg::integral_t  alpha_integral
);
    import rpa_pkg::*;

    sample_t    step_size_reg;
    logic       s1_valid_reg;
    logic       s2_valid_reg;
    logic       s1_first_reg;
    logic       s2_first_reg;
    logic       out_valid_reg;
    logic       out_valid_next;

    logic       accept;
    logic       commit;
    lane_ctrl_t ctrl;
    sample_t    step;
    sample_t    red_sat;
    sample_t    green_sat;
    sample_t    blue_sat;
    sample_t    alpha_sat;
    sample_t    prev_alpha;

    assign cfg_ready = 1'b1;
    assign in_stall  = s1_valid_reg | s2_valid_reg;
    assign accept    = in_valid & ~in_stall;
    assign commit    = s2_valid_reg & (~out_valid_reg | ~out_stall);

    assign step      = sat_q15(step_size_reg);
    assign red_sat   = sat_q15(red_sample);
    assign green_sat = sat_q15(green_sample);
    assign blue_sat  = sat_q15(blue_sample);
    assign alpha_sat = sat_q15(alpha_sample);

    assign ctrl.load   = accept;
    assign ctrl.scale  = s1_valid_reg;
    assign ctrl.commit = commit;
    assign ctrl.first  = s2_first_reg;

    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg & out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg <= 16'd128;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                step_size_reg <= cfg_data;
            end
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg | (s2_valid_reg & ~commit);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_first_reg <= first_sample;
        end
        if (s1_valid_reg)
        begin
            s2_first_reg <= s1_first_reg;
        end
    end

    rpa_color_lane u_red_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .color      (red_sat),
        .alpha      (alpha_sat),
        .prev_alpha (prev_alpha),
        .step       (step),
        .integral   (red_integral)
    );

    rpa_color_lane u_green_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .color      (green_sat),
        .alpha      (alpha_sat),
        .prev_alpha (prev_alpha),
        .step       (step),
        .integral   (green_integral)
    );

    rpa_color_lane u_blue_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .color      (blue_sat),
        .alpha      (alpha_sat),
        .prev_alpha (prev_alpha),
        .step       (step),
        .integral   (blue_integral)
    );

    rpa_alpha_lane u_alpha_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .alpha      (alpha_sat),
        .step       (step),
        .prev_alpha (prev_alpha),
        .integral   (alpha_integral)
    );

    assign out_valid = out_valid_reg;

endmodule
